// ===== rtl/mixed_radix_index_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Mixed radix index unit assertion macros
// Concurrent assertion wrappers on clk and rst; they are empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef MIXED_RADIX_INDEX_UNIT_MACROS_SVH
`define MIXED_RADIX_INDEX_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define MRI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define MRI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MRI_ASSERT_IMP(label, ante, cons, msg)
`define MRI_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/mri_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mixed radix index unit package
// Field widths, command codes and the structs shared by the lanes, the
// pipeline steps and the merging stage.
// ----------------------------------------------------------------------------
package mri_pkg;

  localparam int COORD_BITS     = 8;
  localparam int INDEX_BITS     = 32;
  localparam int AXIS_BITS      = 3;
  localparam int NDIM_BITS      = 4;
  localparam int WORD_BITS      = 64;
  localparam int AXIS_WORD_BITS = 24;
  localparam int IDX_PORT_BITS  = 32;
  localparam int ADDR_BITS      = 5;
  localparam int SHIFT_BITS     = $clog2(COORD_BITS + 1);

  localparam logic [1:0] CMD_ENCODE = 2'd0;
  localparam logic [1:0] CMD_DECODE = 2'd1;
  localparam logic [1:0] CMD_NEXT   = 2'd2;

  // Per storage position settings, derived from the registers
  typedef struct packed {
    logic [AXIS_BITS-1:0]  axis;
    logic                  active;
    logic [COORD_BITS-1:0] radix;
    logic [COORD_BITS-1:0] row_radix;
    logic [INDEX_BITS:0]   rcp;
    logic [SHIFT_BITS-1:0] rcp_shift;
  } lane_cfg_t;

  // Item state as it travels down the position chain
  typedef struct packed {
    logic [1:0]            cmd;
    logic [WORD_BITS-1:0]  coords;
    logic [INDEX_BITS-1:0] row0;
    logic [INDEX_BITS-1:0] rest;
    logic [INDEX_BITS-1:0] stride;
    logic                  stride_ovf;
    logic [INDEX_BITS-1:0] sum;
    logic                  sum_ovf;
    logic [INDEX_BITS-1:0] rows;
    logic                  rows_ovf;
  } pipe_t;

endpackage

// ===== rtl/mri_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mixed radix index lane settings
// Resolves one storage position: its coordinate, radix, row radix and the
// reciprocal used to divide by that radix.
// ----------------------------------------------------------------------------
module mri_lane #(
  parameter int POS = 0
) (
  input  logic [mri_pkg::NDIM_BITS-1:0]      num_used,
  input  logic [mri_pkg::WORD_BITS-1:0]      radices,
  input  logic [mri_pkg::AXIS_WORD_BITS-1:0] axis_order,
  output mri_pkg::lane_cfg_t                 cfg
);
  import mri_pkg::*;

  localparam int RomDepth = 2 ** COORD_BITS;

  logic [INDEX_BITS:0]   rcp_rom   [RomDepth];
  logic [SHIFT_BITS-1:0] shift_rom [RomDepth];
  logic [AXIS_BITS-1:0]  axis;
  logic                  pos_used;
  logic                  active;
  logic [COORD_BITS-1:0] sel_radix;
  logic [COORD_BITS-1:0] own_radix;
  logic [COORD_BITS-1:0] radix;

  // Reciprocal ceil(2^(INDEX_BITS+l)/r), l = clog2(r): exact quotient after shift
  for (genvar r = 0; r < RomDepth; r++) begin : g_rcp
    localparam int Div = (r == 0) ? 1 : r;
    localparam int Lg  = $clog2(Div);
    localparam longint unsigned Mul = ((64'd1 << (INDEX_BITS + Lg)) + Div - 1) / Div;
    assign rcp_rom[r]   = Mul[INDEX_BITS:0];
    assign shift_rom[r] = Lg[SHIFT_BITS-1:0];
  end

  always_comb begin
    axis      = axis_order[POS*AXIS_BITS +: AXIS_BITS];
    pos_used  = NDIM_BITS'(POS) < num_used;
    active    = pos_used && ({1'b0, axis} < num_used);
    sel_radix = radices[axis*COORD_BITS +: COORD_BITS];
    if (sel_radix == '0) sel_radix = COORD_BITS'(1);
    own_radix = radices[POS*COORD_BITS +: COORD_BITS];
    if (own_radix == '0) own_radix = COORD_BITS'(1);
    radix = active ? sel_radix : COORD_BITS'(1);

    cfg.axis      = axis;
    cfg.active    = active;
    cfg.radix     = radix;
    cfg.row_radix = pos_used ? own_radix : COORD_BITS'(1);
    cfg.rcp       = rcp_rom[radix];
    cfg.rcp_shift = shift_rom[radix];
  end

endmodule

// ===== rtl/mri_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mixed radix index pipeline step
// Handles one storage position in two registered halves: multiply, then
// quotient, digit and accumulation.
// ----------------------------------------------------------------------------
module mri_step #(
  parameter int MAX_DIMS = 8,
  parameter int POS      = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  mri_pkg::lane_cfg_t  cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  mri_pkg::pipe_t      in_data,
  input  logic [MAX_DIMS-1:0][mri_pkg::COORD_BITS-1:0] in_digits,
  output logic                out_valid,
  input  logic                out_ready,
  output mri_pkg::pipe_t      out_data,
  output logic [MAX_DIMS-1:0][mri_pkg::COORD_BITS-1:0] out_digits
);
  import mri_pkg::*;

  localparam int WideBits = INDEX_BITS + COORD_BITS;

  typedef struct packed {
    pipe_t                 base;
    logic [2*INDEX_BITS:0] prod;
    logic [WideBits-1:0]   term;
    logic [WideBits-1:0]   stride_wide;
    logic [WideBits-1:0]   rows_wide;
    logic                  digit_nz;
  } mid_t;

  mid_t                  a;
  mid_t                  a_next;
  logic                  a_valid;
  logic                  a_ready;
  logic                  b_ready;
  logic [MAX_DIMS-1:0][COORD_BITS-1:0] a_digits;
  logic [MAX_DIMS-1:0][COORD_BITS-1:0] digits_next;
  logic [COORD_BITS-1:0] coord_sel;
  logic [COORD_BITS-1:0] digit_in;
  logic [2*INDEX_BITS:0] shifted;
  logic [INDEX_BITS-1:0] quot;
  logic [WideBits-1:0]   qr;
  logic [INDEX_BITS-1:0] rem_full;
  logic                  term_ovf;
  logic [INDEX_BITS:0]   sum_full;
  pipe_t                 b_next;

  assign b_ready  = !out_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  // First half: start the reciprocal multiply and the stride products
  always_comb begin
    coord_sel = in_data.coords[cfg.axis*COORD_BITS +: COORD_BITS];
    digit_in  = cfg.active ? coord_sel : '0;
    a_next.base = in_data;
    a_next.prod = {{(INDEX_BITS+1){1'b0}}, in_data.rest} * {{INDEX_BITS{1'b0}}, cfg.rcp};
    a_next.term = {{INDEX_BITS{1'b0}}, digit_in} * {{COORD_BITS{1'b0}}, in_data.stride};
    a_next.stride_wide = {{COORD_BITS{1'b0}}, in_data.stride} *
                         {{INDEX_BITS{1'b0}}, cfg.radix};
    a_next.rows_wide   = {{COORD_BITS{1'b0}}, in_data.rows} *
                         {{INDEX_BITS{1'b0}}, cfg.row_radix};
    a_next.digit_nz = digit_in != '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a        <= a_next;
      a_digits <= in_digits;
    end
  end

  // Second half: quotient, digit, and accumulation with sticky overflow flags
  always_comb begin
    shifted  = a.prod >> cfg.rcp_shift;
    quot     = shifted[INDEX_BITS +: INDEX_BITS];
    qr       = {{COORD_BITS{1'b0}}, quot} * {{INDEX_BITS{1'b0}}, cfg.radix};
    rem_full = a.base.rest - qr[INDEX_BITS-1:0];
    term_ovf = (a.base.stride_ovf && a.digit_nz) || (a.term[WideBits-1:INDEX_BITS] != '0);
    sum_full = {1'b0, a.base.sum} + {1'b0, a.term[INDEX_BITS-1:0]};

    b_next            = a.base;
    b_next.rest       = quot;
    b_next.sum        = sum_full[INDEX_BITS-1:0];
    b_next.sum_ovf    = a.base.sum_ovf || term_ovf || sum_full[INDEX_BITS];
    b_next.stride     = a.stride_wide[INDEX_BITS-1:0];
    b_next.stride_ovf = a.base.stride_ovf || (a.stride_wide[WideBits-1:INDEX_BITS] != '0);
    b_next.rows       = a.rows_wide[INDEX_BITS-1:0];
    b_next.rows_ovf   = a.base.rows_ovf || (a.rows_wide[WideBits-1:INDEX_BITS] != '0);

    digits_next      = a_digits;
    digits_next[POS] = rem_full[COORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      out_data   <= b_next;
      out_digits <= digits_next;
    end
  end

endmodule

// ===== rtl/mri_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mixed radix index merging stage
// Scatters decoded digits to their coordinates, steps the odometer and
// forms the registered result.
// ----------------------------------------------------------------------------
module mri_merge #(
  parameter int MAX_DIMS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [mri_pkg::NDIM_BITS-1:0]      num_used,
  input  logic [mri_pkg::WORD_BITS-1:0]      radices,
  input  mri_pkg::lane_cfg_t                 cfg [MAX_DIMS],
  input  logic                               in_valid,
  output logic                               in_ready,
  input  mri_pkg::pipe_t                     in_data,
  input  logic [MAX_DIMS-1:0][mri_pkg::COORD_BITS-1:0] in_digits,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mri_pkg::IDX_PORT_BITS-1:0]  out_index,
  output logic [mri_pkg::WORD_BITS-1:0]      out_coords,
  output logic                               out_of_range,
  output logic                               wrapped
);
  import mri_pkg::*;

  logic [COORD_BITS-1:0]    dig;
  logic [COORD_BITS-1:0]    cur;
  logic [COORD_BITS-1:0]    rad;
  logic [COORD_BITS:0]      inc;
  logic                     last;
  logic                     above;
  logic [WORD_BITS-1:0]     dec_coords;
  logic [WORD_BITS-1:0]     nxt_coords;
  logic                     enc_oor;
  logic                     dec_oor;
  logic [IDX_PORT_BITS-1:0] index_next;
  logic [WORD_BITS-1:0]     coords_next;
  logic                     oor_next;
  logic                     wrap_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    // Most significant position naming a coordinate wins
    dec_coords = '0;
    for (int c = 0; c < MAX_DIMS; c++) begin
      dig = '0;
      for (int p = MAX_DIMS - 1; p >= 0; p--) begin
        if (cfg[p].active && cfg[p].axis == AXIS_BITS'(c)) dig = in_digits[p];
      end
      dec_coords[c*COORD_BITS +: COORD_BITS] = dig;
    end

    // Odometer: last used coordinate turns fastest
    nxt_coords = '0;
    above      = 1'b1;
    cur        = '0;
    rad        = '0;
    inc        = '0;
    last       = 1'b0;
    for (int k = MAX_DIMS - 1; k >= 0; k--) begin
      if (NDIM_BITS'(k) < num_used) begin
        cur = in_data.coords[k*COORD_BITS +: COORD_BITS];
        rad = radices[k*COORD_BITS +: COORD_BITS];
        if (rad == '0) rad = COORD_BITS'(1);
        inc  = {1'b0, cur} + (COORD_BITS+1)'(1);
        last = inc >= {1'b0, rad};
        if (above) begin
          nxt_coords[k*COORD_BITS +: COORD_BITS] = last ? '0 : inc[COORD_BITS-1:0];
        end else begin
          nxt_coords[k*COORD_BITS +: COORD_BITS] = cur;
        end
        above = above && last;
      end
    end

    enc_oor = in_data.sum_ovf || (!in_data.rows_ovf && in_data.sum >= in_data.rows);
    dec_oor = !in_data.rows_ovf && in_data.row0 >= in_data.rows;

    index_next  = '0;
    coords_next = '0;
    oor_next    = 1'b0;
    wrap_next   = 1'b0;
    case (in_data.cmd)
      CMD_ENCODE: begin
        index_next = IDX_PORT_BITS'(in_data.sum);
        oor_next   = enc_oor;
      end
      CMD_DECODE: begin
        coords_next = dec_coords;
        oor_next    = dec_oor;
      end
      CMD_NEXT: begin
        coords_next = nxt_coords;
        wrap_next   = above;
      end
      default: begin
        index_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_index    <= index_next;
      out_coords   <= coords_next;
      out_of_range <= oor_next;
      wrapped      <= wrap_next;
    end
  end

endmodule

// ===== rtl/mixed_radix_index_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mixed radix index unit
// Encodes coordinate tuples to row indices, decodes indices to tuples and
// steps tuples like an odometer, under a configurable axis order.
// ----------------------------------------------------------------------------
// Takes one transfer per clock while in_ready is high and returns one result
// transfer per item, in order, through the step registers and the output
// register. Each storage position owns one pipeline step of two registers (a
// multiply half, then a quotient and accumulate half), walked from the least
// significant position up; the chain of MAX_DIMS steps plus the output
// register sets the latency. Per-position lanes decode the axis order and
// radices and look up a reciprocal, so decode divides by multiplication
// rather than by an iterative divider. Stalls on the output back up through
// the step registers; empty slots are squeezed out, so input is taken while
// any slot is free. Registers sit on an APB-style port at byte addresses 0
// (num_dims), 8 (radices) and 16 (axis_order) and must only be written while
// no transfer is in flight. There is no memory and no clearing pass.
// ----------------------------------------------------------------------------
`include "mixed_radix_index_unit_macros.svh"

module mixed_radix_index_unit #(
  parameter int MAX_DIMS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mri_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [mri_pkg::WORD_BITS-1:0]      pwdata,
  output logic [mri_pkg::WORD_BITS-1:0]      prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         command,
  input  logic [mri_pkg::WORD_BITS-1:0]      coords,
  input  logic [mri_pkg::IDX_PORT_BITS-1:0]  row_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mri_pkg::IDX_PORT_BITS-1:0]  out_index,
  output logic [mri_pkg::WORD_BITS-1:0]      out_coords,
  output logic                               out_of_range,
  output logic                               wrapped
);
  import mri_pkg::*;

  localparam logic [1:0] REG_NUM_DIMS   = 2'd0;
  localparam logic [1:0] REG_RADICES    = 2'd1;
  localparam logic [1:0] REG_AXIS_ORDER = 2'd2;

  localparam logic [NDIM_BITS-1:0]      NumDimsReset = 4'd1;
  localparam logic [WORD_BITS-1:0]      RadicesReset = 64'h0101_0101_0101_0101;
  localparam logic [AXIS_WORD_BITS-1:0] AxisReset    = 24'hFAC688;

  logic [NDIM_BITS-1:0]      num_dims;
  logic [WORD_BITS-1:0]      radices;
  logic [AXIS_WORD_BITS-1:0] axis_order;
  logic [NDIM_BITS-1:0]      num_used;
  logic                      cfg_wr;
  logic [1:0]                reg_sel;

  lane_cfg_t lane_cfg [MAX_DIMS];

  logic  stg_valid [MAX_DIMS+1];
  logic  stg_ready [MAX_DIMS+1];
  pipe_t stg_data  [MAX_DIMS+1];
  logic [MAX_DIMS-1:0][COORD_BITS-1:0] stg_digits [MAX_DIMS+1];

  // Register port: zero wait states, index in the upper address bits
  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_BITS-1:ADDR_BITS-2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims   <= NumDimsReset;
      radices    <= RadicesReset;
      axis_order <= AxisReset;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_NUM_DIMS:   num_dims   <= pwdata[NDIM_BITS-1:0];
        REG_RADICES:    radices    <= pwdata;
        REG_AXIS_ORDER: axis_order <= pwdata[AXIS_WORD_BITS-1:0];
        default: begin
          num_dims <= num_dims;
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_NUM_DIMS:   prdata = WORD_BITS'(num_dims);
      REG_RADICES:    prdata = radices;
      REG_AXIS_ORDER: prdata = WORD_BITS'(axis_order);
      default:        prdata = '0;
    endcase
  end

  // Clamp the dimension count: zero acts as one, excess as MAX_DIMS
  always_comb begin
    if (num_dims == '0) begin
      num_used = NDIM_BITS'(1);
    end else if (num_dims > NDIM_BITS'(MAX_DIMS)) begin
      num_used = NDIM_BITS'(MAX_DIMS);
    end else begin
      num_used = num_dims;
    end
  end

  // Per-position lanes
  for (genvar p = 0; p < MAX_DIMS; p++) begin : g_lane
    mri_lane #(
      .POS(p)
    ) u_lane (
      .num_used  (num_used),
      .radices   (radices),
      .axis_order(axis_order),
      .cfg       (lane_cfg[p])
    );
  end

  // Seed the chain: stride and row count start at one, sum at zero
  assign stg_valid[0] = in_valid;
  assign stg_data[0]  = '{
    cmd:        command,
    coords:     coords,
    row0:       row_index[INDEX_BITS-1:0],
    rest:       row_index[INDEX_BITS-1:0],
    stride:     INDEX_BITS'(1),
    stride_ovf: 1'b0,
    sum:        '0,
    sum_ovf:    1'b0,
    rows:       INDEX_BITS'(1),
    rows_ovf:   1'b0
  };
  assign stg_digits[0] = '0;
  assign in_ready = stg_ready[0];

  // Least significant position first
  for (genvar i = 0; i < MAX_DIMS; i++) begin : g_step
    mri_step #(
      .MAX_DIMS(MAX_DIMS),
      .POS     (MAX_DIMS - 1 - i)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .cfg       (lane_cfg[MAX_DIMS-1-i]),
      .in_valid  (stg_valid[i]),
      .in_ready  (stg_ready[i]),
      .in_data   (stg_data[i]),
      .in_digits (stg_digits[i]),
      .out_valid (stg_valid[i+1]),
      .out_ready (stg_ready[i+1]),
      .out_data  (stg_data[i+1]),
      .out_digits(stg_digits[i+1])
    );
  end

  mri_merge #(
    .MAX_DIMS(MAX_DIMS)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .num_used    (num_used),
    .radices     (radices),
    .cfg         (lane_cfg),
    .in_valid    (stg_valid[MAX_DIMS]),
    .in_ready    (stg_ready[MAX_DIMS]),
    .in_data     (stg_data[MAX_DIMS]),
    .in_digits   (stg_digits[MAX_DIMS]),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_index   (out_index),
    .out_coords  (out_coords),
    .out_of_range(out_of_range),
    .wrapped     (wrapped)
  );

  // Input is refused only when every slot is full and the result is held
  `MRI_ASSERT_IMP(a_full_only_when_held, !in_ready, out_valid && !out_ready, "input refused")
  // An encode result never carries a tuple
  `MRI_ASSERT_IMP(a_index_excludes_tuple, out_valid && out_index != '0, out_coords == '0, "index and tuple")
  // A wrap comes only from the odometer, which raises no range flag
  `MRI_ASSERT_IMP(a_wrap_alone, out_valid && wrapped, !out_of_range && out_index == '0, "wrap mixed")

endmodule
